// ----- rtl/core/fgil_pkg.sv -----
// shared types, constants and command codes for the glyph index lookup
`timescale 1ns / 1ps
package fgil_pkg;

    localparam int MapSectionsDef    = 8;
    localparam int MapWordsDef       = 4096;
    localparam int MetricSectionsDef = 4;
    localparam int MetricEntriesDef  = 1024;

    typedef enum logic [2:0] {
        CMD_LOOKUP     = 3'd0,
        CMD_MAP_SECT   = 3'd1,
        CMD_MAP_WORD   = 3'd2,
        CMD_MET_SECT   = 3'd3,
        CMD_MET_ENTRY  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        REG_DEFAULT_GLYPH = 3'd0,
        REG_CELL_BYTES    = 3'd1,
        REG_BITMAP_BASE   = 3'd2,
        REG_FB_LEFT       = 3'd3,
        REG_FB_WIDTH      = 3'd4,
        REG_FB_ADVANCE    = 3'd5,
        REG_MAP_COUNT     = 3'd6,
        REG_MET_COUNT     = 3'd7
    } reg_idx_t;

    localparam logic [1:0] METHOD_OFFSET = 2'd0;
    localparam logic [1:0] METHOD_DIRECT = 2'd1;
    localparam logic [1:0] METHOD_PAIRS  = 2'd2;
    localparam logic [1:0] METHOD_SKIP   = 2'd3;

    localparam logic [15:0] NO_GLYPH = 16'hFFFF;

    // transaction queued between front and back
    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] char_code;
        logic [2:0]  slot;
        logic [11:0] addr;
        logic [15:0] range_begin;
        logic [15:0] range_end;
        logic [1:0]  method;
        logic [11:0] info_base;
        logic [15:0] word_value;
        logic [7:0]  entry_left;
        logic [7:0]  entry_width;
        logic [7:0]  entry_advance;
    } txn_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SECT,
        ST_WAIT1,
        ST_EVAL1,
        ST_PCNT,
        ST_PMID,
        ST_PRD,
        ST_PCMP,
        ST_PWAIT,
        ST_PIDX,
        ST_MSCAN,
        ST_MRD,
        ST_MUL,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/core/fgil_ram.sv -----
// generic single-port write, single-port read ram with registered read
`timescale 1ns / 1ps
module fgil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/core/fgil_front.sv -----
// front end: accepts commands, drops unknown ones and any that arrive while full, queues the rest
`timescale 1ns / 1ps
module fgil_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fgil_pkg::txn_t      in_txn,
    output logic                q_valid,
    output fgil_pkg::txn_t      q_txn,
    input  logic                q_pop
);
    import fgil_pkg::*;

    localparam int Depth = 2;

    txn_t       buf_reg [Depth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       known;

    // classify: only defined commands enter the queue
    always_comb
    begin
        known = (in_txn.cmd == CMD_LOOKUP) || (in_txn.cmd == CMD_MAP_SECT) ||
                (in_txn.cmd == CMD_MAP_WORD) || (in_txn.cmd == CMD_MET_SECT) ||
                (in_txn.cmd == CMD_MET_ENTRY);
    end

    assign busy    = (cnt_reg == 2'(Depth));
    assign push    = start && !busy && known;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_txn   = buf_reg[rd_ptr_reg];

    // pointer and count updates
    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_txn;
        end
    end
endmodule

// ----- rtl/core/fgil_back.sv -----
// back end: table writes, section scan, pair search, metrics and address
`timescale 1ns / 1ps
module fgil_back #(
    parameter int MAP_SECTIONS    = 8,
    parameter int MAP_WORDS       = 4096,
    parameter int METRIC_SECTIONS = 4,
    parameter int METRIC_ENTRIES  = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  fgil_pkg::txn_t      q_txn,
    output logic                q_pop,
    input  logic [15:0]         default_glyph,
    input  logic [15:0]         cell_bytes,
    input  logic [31:0]         bitmap_base,
    input  logic [7:0]          fallback_left,
    input  logic [7:0]          fallback_width,
    input  logic [7:0]          fallback_advance,
    input  logic [3:0]          map_section_count,
    input  logic [2:0]          metric_section_count,
    output logic                done,
    output logic [15:0]         glyph_index,
    output logic [31:0]         glyph_address,
    output logic signed [7:0]   left_bearing,
    output logic [7:0]          cell_width,
    output logic signed [7:0]   advance_width,
    output logic                mapped
);
    import fgil_pkg::*;

    localparam int MsW = (MAP_SECTIONS > 1) ? $clog2(MAP_SECTIONS) : 1;
    localparam int KsW = (METRIC_SECTIONS > 1) ? $clog2(METRIC_SECTIONS) : 1;
    localparam int MwW = $clog2(MAP_WORDS);
    localparam int MeW = $clog2(METRIC_ENTRIES);
    localparam int MsC = $clog2(MAP_SECTIONS + 1);
    localparam int KsC = $clog2(METRIC_SECTIONS + 1);

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [1:0]  method;
        logic [11:0] base;
    } desc_t;

    desc_t map_desc_reg [MAP_SECTIONS];
    desc_t met_desc_reg [METRIC_SECTIONS];

    state_t state_reg, state_next;
    txn_t   txn_reg;

    logic [MsC-1:0] sec_reg, sec_next;
    logic [KsC-1:0] msec_reg;
    logic [MsC-1:0] map_lim;
    logic [KsC-1:0] met_lim;
    logic [16:0]    lo_reg, hi_reg;
    logic [15:0]    idx_reg;
    logic           hit_reg;
    logic [23:0]    met_reg;
    logic [31:0]    prod_reg;

    // ram ports
    logic           mw_we;
    logic [MwW-1:0] mw_waddr, mw_raddr;
    logic [15:0]    mw_rdata;
    logic           me_we;
    logic [MeW-1:0] me_waddr, me_raddr;
    logic [23:0]    me_rdata;
    logic [MwW-1:0] rd_addr_reg;

    desc_t cur_desc, cur_met;
    logic  sec_match, met_match;
    logic [16:0] mid;
    logic [MwW-1:0] pair_addr;

    fgil_ram #(.WIDTH(16), .DEPTH(MAP_WORDS)) u_map_words (
        .clk(clk), .we(mw_we), .waddr(mw_waddr), .wdata(txn_reg.word_value),
        .raddr(mw_raddr), .rdata(mw_rdata)
    );

    fgil_ram #(.WIDTH(24), .DEPTH(METRIC_ENTRIES)) u_met_entries (
        .clk(clk), .we(me_we), .waddr(me_waddr),
        .wdata({txn_reg.entry_advance, txn_reg.entry_width, txn_reg.entry_left}),
        .raddr(me_raddr), .rdata(me_rdata)
    );

    // section limits and current descriptors
    always_comb
    begin
        map_lim = (32'(map_section_count) > MAP_SECTIONS) ?
                  MsC'(MAP_SECTIONS) : MsC'(map_section_count);
        met_lim = (32'(metric_section_count) > METRIC_SECTIONS) ?
                  KsC'(METRIC_SECTIONS) : KsC'(metric_section_count);
        cur_desc  = map_desc_reg[sec_reg[MsW-1:0]];
        cur_met   = met_desc_reg[msec_reg[KsW-1:0]];
        sec_match = (txn_reg.char_code >= cur_desc.lo) &&
                    (txn_reg.char_code <= cur_desc.hi);
        met_match = (idx_reg >= cur_met.lo) && (idx_reg <= cur_met.hi);
        mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
        pair_addr = MwW'(32'(cur_desc.base) + 32'd1 + 2 * 32'(mid[15:0]));
        mw_we     = (state_reg == ST_SECT) && (txn_reg.cmd == CMD_MAP_WORD);
        mw_waddr  = MwW'(txn_reg.addr);
        me_we     = (state_reg == ST_SECT) && (txn_reg.cmd == CMD_MET_ENTRY);
        me_waddr  = MeW'(txn_reg.addr);
        me_raddr  = MeW'(32'(cur_met.base) + 32'(idx_reg - cur_met.lo));
        mw_raddr  = rd_addr_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_SECT;
            ST_SECT:
            begin
                if (txn_reg.cmd != CMD_LOOKUP)    state_next = ST_IDLE;
                else if (sec_reg >= map_lim)      state_next = ST_MSCAN;
                else if (sec_match && cur_desc.method != METHOD_SKIP) state_next = ST_WAIT1;
            end
            ST_WAIT1: state_next = ST_EVAL1;
            ST_EVAL1:
            begin
                if (cur_desc.method == METHOD_PAIRS) state_next = ST_PCNT;
                else                                 state_next = ST_MSCAN;
            end
            ST_PCNT:  state_next = ST_PMID;
            ST_PMID:
            begin
                if ($signed(lo_reg) > $signed(hi_reg)) state_next = ST_SECT;
                else                                   state_next = ST_PRD;
            end
            ST_PRD:   state_next = ST_PCMP;
            ST_PCMP:
            begin
                if (mw_rdata == txn_reg.char_code) state_next = ST_PWAIT;
                else                               state_next = ST_PMID;
            end
            ST_PWAIT: state_next = ST_PIDX;
            ST_PIDX:  state_next = ST_MSCAN;
            ST_MSCAN:
            begin
                if (msec_reg >= met_lim || met_match) state_next = ST_MRD;
            end
            ST_MRD:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop    = (state_reg == ST_IDLE) && q_valid;
        done     = (state_reg == ST_OUT);
        sec_next = sec_reg;
        if (state_reg == ST_IDLE)
        begin
            sec_next = '0;
        end
        else if ((state_reg == ST_SECT && !(sec_match && cur_desc.method != METHOD_SKIP)) ||
                 (state_reg == ST_PMID && $signed(lo_reg) > $signed(hi_reg)))
        begin
            sec_next = sec_reg + MsC'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sec_reg <= sec_next;
        unique case (state_reg)
            ST_IDLE:
            begin
                txn_reg  <= q_txn;
                msec_reg <= '0;
                hit_reg  <= 1'b0;
                idx_reg  <= default_glyph;
            end
            ST_SECT:
            begin
                if (txn_reg.cmd == CMD_MAP_SECT &&
                    32'(txn_reg.slot) < MAP_SECTIONS)
                begin
                    map_desc_reg[MsW'(txn_reg.slot)] <= {txn_reg.range_begin,
                        txn_reg.range_end, txn_reg.method, txn_reg.info_base};
                end
                if (txn_reg.cmd == CMD_MET_SECT &&
                    32'(txn_reg.slot) < METRIC_SECTIONS)
                begin
                    met_desc_reg[KsW'(txn_reg.slot)] <= {txn_reg.range_begin,
                        txn_reg.range_end, METHOD_OFFSET, txn_reg.info_base};
                end
                if (cur_desc.method == METHOD_DIRECT)
                begin
                    rd_addr_reg <= MwW'(32'(cur_desc.base) +
                                        32'(txn_reg.char_code - cur_desc.lo));
                end
                else
                begin
                    rd_addr_reg <= MwW'(cur_desc.base);
                end
            end
            ST_EVAL1:
            begin
                if (cur_desc.method == METHOD_OFFSET)
                begin
                    idx_reg <= txn_reg.char_code - cur_desc.lo + mw_rdata;
                    hit_reg <= 1'b1;
                end
                else if (cur_desc.method == METHOD_DIRECT)
                begin
                    if (mw_rdata != NO_GLYPH)
                    begin
                        idx_reg <= mw_rdata;
                        hit_reg <= 1'b1;
                    end
                end
                lo_reg <= '0;
            end
            ST_PCNT:  hi_reg <= {1'b0, mw_rdata} - 17'd1;
            ST_PMID:  rd_addr_reg <= pair_addr;
            ST_PCMP:
            begin
                if (mw_rdata < txn_reg.char_code)      lo_reg <= mid + 17'd1;
                else if (mw_rdata > txn_reg.char_code) hi_reg <= mid - 17'd1;
                else                                    rd_addr_reg <= rd_addr_reg + MwW'(1);
            end
            ST_PIDX:
            begin
                idx_reg <= mw_rdata;
                hit_reg <= 1'b1;
            end
            ST_MSCAN:
            begin
                if (msec_reg < met_lim && !met_match) msec_reg <= msec_reg + KsC'(1);
            end
            ST_MUL:
            begin
                prod_reg <= 32'(cell_bytes) * 32'(idx_reg);
                if (msec_reg < met_lim) met_reg <= me_rdata;
                else met_reg <= {fallback_advance, fallback_width, fallback_left};
            end
            default: ;
        endcase
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            glyph_index <= idx_reg;
            mapped      <= hit_reg;
        end
    end

    always_comb
    begin
        glyph_address = bitmap_base + prod_reg;
        left_bearing  = $signed(met_reg[7:0]);
        cell_width    = met_reg[15:8];
        advance_width = $signed(met_reg[23:16]);
    end
endmodule

// ----- rtl/core/font_glyph_index_lookup.sv -----
// top level: configuration registers, command queue and lookup engine
// a lookup scans the map sections, reads the map word and runs any pair search, then scans the
//   metric sections, reads the metric entry and forms the address before the result strobe
// one command at a time in the engine; a two-entry queue takes commands; results cannot stall
// reset clears configuration registers, queue pointers and control state; tables are undefined until written
`timescale 1ns / 1ps
module font_glyph_index_lookup #(
    parameter int MAP_SECTIONS    = fgil_pkg::MapSectionsDef,
    parameter int MAP_WORDS       = fgil_pkg::MapWordsDef,
    parameter int METRIC_SECTIONS = fgil_pkg::MetricSectionsDef,
    parameter int METRIC_ENTRIES  = fgil_pkg::MetricEntriesDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [2:0]         cmd,
    input  logic [15:0]        char_code,
    input  logic [2:0]         slot,
    input  logic [11:0]        addr,
    input  logic [15:0]        range_begin,
    input  logic [15:0]        range_end,
    input  logic [1:0]         method,
    input  logic [11:0]        info_base,
    input  logic [15:0]        word_value,
    input  logic signed [7:0]  entry_left,
    input  logic [7:0]         entry_width,
    input  logic signed [7:0]  entry_advance,
    output logic               result_valid,
    output logic [15:0]        glyph_index,
    output logic [31:0]        glyph_address,
    output logic signed [7:0]  left_bearing,
    output logic [7:0]         cell_width,
    output logic signed [7:0]  advance_width,
    output logic               mapped
);
    import fgil_pkg::*;

    logic [15:0] default_glyph_reg, cell_bytes_reg;
    logic [31:0] bitmap_base_reg;
    logic [7:0]  fb_left_reg, fb_width_reg, fb_adv_reg;
    logic [3:0]  map_cnt_reg;
    logic [2:0]  met_cnt_reg;

    txn_t in_txn, q_txn;
    logic q_valid, q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_glyph_reg <= '0;
            cell_bytes_reg    <= '0;
            bitmap_base_reg   <= '0;
            fb_left_reg       <= '0;
            fb_width_reg      <= '0;
            fb_adv_reg        <= '0;
            map_cnt_reg       <= '0;
            met_cnt_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DEFAULT_GLYPH: default_glyph_reg <= cfg_data[15:0];
                REG_CELL_BYTES:    cell_bytes_reg    <= cfg_data[15:0];
                REG_BITMAP_BASE:   bitmap_base_reg   <= cfg_data;
                REG_FB_LEFT:       fb_left_reg       <= cfg_data[7:0];
                REG_FB_WIDTH:      fb_width_reg      <= cfg_data[7:0];
                REG_FB_ADVANCE:    fb_adv_reg        <= cfg_data[7:0];
                REG_MAP_COUNT:     map_cnt_reg       <= cfg_data[3:0];
                REG_MET_COUNT:     met_cnt_reg       <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_txn = '{cmd, char_code, slot, addr, range_begin, range_end, method,
                   info_base, word_value, entry_left, entry_width, entry_advance};
    end

    fgil_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_txn(in_txn),
        .q_valid(q_valid), .q_txn(q_txn), .q_pop(q_pop)
    );

    fgil_back #(
        .MAP_SECTIONS(MAP_SECTIONS), .MAP_WORDS(MAP_WORDS),
        .METRIC_SECTIONS(METRIC_SECTIONS), .METRIC_ENTRIES(METRIC_ENTRIES)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_txn(q_txn), .q_pop(q_pop),
        .default_glyph(default_glyph_reg), .cell_bytes(cell_bytes_reg),
        .bitmap_base(bitmap_base_reg), .fallback_left(fb_left_reg),
        .fallback_width(fb_width_reg), .fallback_advance(fb_adv_reg),
        .map_section_count(map_cnt_reg), .metric_section_count(met_cnt_reg),
        .done(result_valid), .glyph_index(glyph_index),
        .glyph_address(glyph_address), .left_bearing(left_bearing),
        .cell_width(cell_width), .advance_width(advance_width), .mapped(mapped)
    );
endmodule
